### hdl/ia_pkg.sv
// ---------------------------------------------------------------------------
// ia_pkg: shared types and constants for the interval arithmetic ALU
// Operation codes, request/response word layouts, divider pipeline depth.
// ---------------------------------------------------------------------------
package ia_pkg;

   localparam int unsigned DivStages   = 32;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_SDIV = 3'd3,
      OP_SREM = 3'd4,
      OP_SHL  = 3'd5,
      OP_LSHR = 3'd6,
      OP_ASHR = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] left_lower;
      logic signed [31:0] left_upper;
      logic               left_unknown;
      logic signed [31:0] right_lower;
      logic signed [31:0] right_upper;
      logic               right_unknown;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_lower;
      logic signed [63:0] result_upper;
      logic               result_unknown;
      logic               error;
   } rsp_type;

   // Control that travels beside the corner values.
   typedef struct packed {
      logic   valid;
      logic   top;
      logic   err;
      logic   direct;
   } ctl_type;

endpackage

### hdl/ia_corner.sv
// ---------------------------------------------------------------------------
// ia_corner: one corner lane of the interval ALU
// Pipelined evaluation of a op b for mul, sdiv, srem and the shifts.
// Division is a restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ia_corner (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ia_pkg::op_type      in_op,
   input  logic signed [31:0]  in_a,
   input  logic signed [31:0]  in_b,
   output logic signed [63:0]  out_value
);
   import ia_pkg::*;

   localparam int unsigned N = DivStages;

   // stage arrays of the shared pipeline
   logic              v_ff    [N+1];
   op_type            op_ff   [N+1];
   logic [31:0]       quo_ff  [N+1];   // dividend bits shifting out / quotient in
   logic [32:0]       rem_ff  [N+1];
   logic [31:0]       dvs_ff  [N+1];
   logic              qneg_ff [N+1];
   logic              rneg_ff [N+1];
   logic signed [63:0] oth_ff [N+1];   // mul/shift result riding along

   logic [31:0] abs_a, abs_b, ua;
   logic [4:0]  sh;
   logic signed [63:0] oth_in;

   always_comb begin
      abs_a = in_a[31] ? (~in_a + 32'd1) : in_a;
      abs_b = in_b[31] ? (~in_b + 32'd1) : in_b;
      ua    = in_a;
      sh    = in_b[4:0];
      case (in_op)
         OP_MUL:  oth_in = 64'(in_a) * 64'(in_b);
         OP_SHL:  oth_in = 64'(signed'(ua << sh));
         OP_LSHR: oth_in = {32'd0, ua >> sh};
         OP_ASHR: oth_in = 64'(signed'(in_a >>> sh));
         default: oth_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
      op_ff[0]   <= in_op;
      quo_ff[0]  <= abs_a;
      rem_ff[0]  <= '0;
      dvs_ff[0]  <= abs_b;
      qneg_ff[0] <= in_a[31] ^ in_b[31];
      rneg_ff[0] <= in_a[31];
      oth_ff[0]  <= oth_in;
   end

   for (genvar g = 0; g < N; g++) begin : g_div
      logic [32:0] trial;
      logic [32:0] sub;
      always_comb begin
         trial = {rem_ff[g][31:0], quo_ff[g][31]};
         sub   = trial - {1'b0, dvs_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[g+1] <= 1'b0;
         else       v_ff[g+1] <= v_ff[g];
         op_ff[g+1]   <= op_ff[g];
         dvs_ff[g+1]  <= dvs_ff[g];
         qneg_ff[g+1] <= qneg_ff[g];
         rneg_ff[g+1] <= rneg_ff[g];
         oth_ff[g+1]  <= oth_ff[g];
         if (!sub[32]) begin
            rem_ff[g+1] <= sub;
            quo_ff[g+1] <= {quo_ff[g][30:0], 1'b1};
         end else begin
            rem_ff[g+1] <= trial;
            quo_ff[g+1] <= {quo_ff[g][30:0], 1'b0};
         end
      end
   end

   logic signed [63:0] q64, r64;
   always_comb begin
      q64 = qneg_ff[N] ? -$signed({32'd0, quo_ff[N]}) : $signed({32'd0, quo_ff[N]});
      r64 = rneg_ff[N] ? -$signed({31'd0, rem_ff[N]}) : $signed({31'd0, rem_ff[N]});
      case (op_ff[N])
         OP_SDIV: out_value = q64;
         OP_SREM: out_value = r64;
         default: out_value = oth_ff[N];
      endcase
   end

   a_rem_fit: assert property (@(posedge clock) disable iff (reset)
      v_ff[N] && (op_ff[N] == OP_SDIV || op_ff[N] == OP_SREM) |-> !rem_ff[N][32])
      else $error("remainder overflow");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      v_ff[N] && (op_ff[N] == OP_SDIV || op_ff[N] == OP_SREM) && dvs_ff[N] != '0
         |-> rem_ff[N][31:0] < dvs_ff[N])
      else $error("remainder not below divisor");
   a_valid_age: assert property (@(posedge clock) disable iff (reset)
      v_ff[N] |-> $past(in_valid, N+1))
      else $error("lane valid without input");

endmodule

### hdl/ia_minmax.sv
// ---------------------------------------------------------------------------
// ia_minmax: registered min/max tree over four corner values
// A pairwise compare stage, then a final compare and top/error output select.
// ---------------------------------------------------------------------------
module ia_minmax (
   input  logic                clock,
   input  logic                reset,
   input  ia_pkg::ctl_type     in_ctl,
   input  logic signed [63:0]  in_c0,
   input  logic signed [63:0]  in_c1,
   input  logic signed [63:0]  in_c2,
   input  logic signed [63:0]  in_c3,
   input  logic signed [63:0]  in_dlo,
   input  logic signed [63:0]  in_dhi,
   output logic                out_strobe,
   output ia_pkg::rsp_type     out_rsp
);
   import ia_pkg::*;

   ctl_type ctl_ff;
   logic signed [63:0] lo0_ff, hi0_ff, lo1_ff, hi1_ff, dlo_ff, dhi_ff;
   rsp_type rsp_ff, rsp_in;
   logic    stb_ff;

   always_ff @(posedge clock) begin
      if (reset) ctl_ff.valid <= 1'b0;
      else       ctl_ff.valid <= in_ctl.valid;
      ctl_ff.top    <= in_ctl.top;
      ctl_ff.err    <= in_ctl.err;
      ctl_ff.direct <= in_ctl.direct;
      lo0_ff <= (in_c1 < in_c0) ? in_c1 : in_c0;
      hi0_ff <= (in_c1 > in_c0) ? in_c1 : in_c0;
      lo1_ff <= (in_c3 < in_c2) ? in_c3 : in_c2;
      hi1_ff <= (in_c3 > in_c2) ? in_c3 : in_c2;
      dlo_ff <= in_dlo;
      dhi_ff <= in_dhi;
   end

   always_comb begin
      rsp_in = '0;
      if (ctl_ff.top) begin
         rsp_in.result_unknown = 1'b1;
         rsp_in.error          = ctl_ff.err;
      end else if (ctl_ff.direct) begin
         rsp_in.result_lower = dlo_ff;
         rsp_in.result_upper = dhi_ff;
      end else begin
         rsp_in.result_lower = (lo1_ff < lo0_ff) ? lo1_ff : lo0_ff;
         rsp_in.result_upper = (hi1_ff > hi0_ff) ? hi1_ff : hi0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stb_ff <= 1'b0;
      else       stb_ff <= ctl_ff.valid;
      rsp_ff <= rsp_in;
   end

   assign out_strobe = stb_ff;
   assign out_rsp    = rsp_ff;

   a_err_top: assert property (@(posedge clock) disable iff (reset)
      out_strobe && out_rsp.error |-> out_rsp.result_unknown)
      else $error("error without top");
   a_top_zero: assert property (@(posedge clock) disable iff (reset)
      out_strobe && out_rsp.result_unknown |->
         out_rsp.result_lower == 64'sd0 && out_rsp.result_upper == 64'sd0)
      else $error("top result has nonzero bounds");
   a_stb_follow: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |=> out_strobe)
      else $error("lost result");

endmodule

### hdl/interval_arithmetic_alu.sv
// ---------------------------------------------------------------------------
// interval_arithmetic_alu: pipelined interval ALU
// Applies one of eight operations to two signed 32-bit intervals.
// ---------------------------------------------------------------------------
// Usage: drive req_word with the operation and both intervals and raise start.
// busy is always low, so a word is taken on every cycle start is high; one
// word may follow another in every cycle.
// Each request gives exactly one response word on rsp_word, marked by
// rsp_strobe for a single cycle, in request order. Each operation passes
// through one input stage, 32 divider stages (one quotient bit each,
// shared by all operations so order is kept), one min/max compare stage and
// the output register. Throughput is one word per cycle.
// The receiver cannot stall; the response must be taken when strobed.
// Reset clears all valid bits; no response appears after reset until a new
// request arrives.
// ---------------------------------------------------------------------------
module interval_arithmetic_alu (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ia_pkg::req_type req_word,
   output logic            rsp_strobe,
   output ia_pkg::rsp_type rsp_word
);
   import ia_pkg::*;

   logic    acc;
   op_type  op;
   logic    bad_div, bad_shift, top, err, direct;
   logic signed [63:0] dlo, dhi;
   logic signed [63:0] c0, c1, c2, c3;
   ctl_type ctl_ff [DivStages+1];
   logic signed [63:0] dlo_ff [DivStages+1];
   logic signed [63:0] dhi_ff [DivStages+1];

   assign busy = 1'b0;
   assign acc  = start && !busy;

   function automatic logic shamt_bad(input logic signed [31:0] v);
      shamt_bad = v[31] || (v[30:5] != '0);
   endfunction

   always_comb begin
      op        = op_type'(req_word.action);
      bad_div   = (op == OP_SDIV || op == OP_SREM) &&
                  (req_word.right_lower == '0 || req_word.right_upper == '0);
      bad_shift = (op == OP_SHL || op == OP_LSHR || op == OP_ASHR) &&
                  (shamt_bad(req_word.right_lower) || shamt_bad(req_word.right_upper));
      top    = req_word.left_unknown || req_word.right_unknown || bad_div || bad_shift;
      err    = !(req_word.left_unknown || req_word.right_unknown) && (bad_div || bad_shift);
      direct = (op == OP_ADD || op == OP_SUB);
      if (op == OP_ADD) begin
         dlo = 64'(req_word.left_lower) + 64'(req_word.right_lower);
         dhi = 64'(req_word.left_upper) + 64'(req_word.right_upper);
      end else begin
         dlo = 64'(req_word.left_lower) - 64'(req_word.right_upper);
         dhi = 64'(req_word.left_upper) - 64'(req_word.right_lower);
      end
   end

   // side pipeline for control and add/sub bounds, aligned with the lanes
   always_ff @(posedge clock) begin
      if (reset) ctl_ff[0].valid <= 1'b0;
      else       ctl_ff[0].valid <= acc;
      ctl_ff[0].top    <= top;
      ctl_ff[0].err    <= err;
      ctl_ff[0].direct <= direct;
      dlo_ff[0] <= dlo;
      dhi_ff[0] <= dhi;
   end

   for (genvar g = 0; g < DivStages; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) ctl_ff[g+1].valid <= 1'b0;
         else       ctl_ff[g+1].valid <= ctl_ff[g].valid;
         ctl_ff[g+1].top    <= ctl_ff[g].top;
         ctl_ff[g+1].err    <= ctl_ff[g].err;
         ctl_ff[g+1].direct <= ctl_ff[g].direct;
         dlo_ff[g+1] <= dlo_ff[g];
         dhi_ff[g+1] <= dhi_ff[g];
      end
   end

   ia_corner u_c0 (.clock, .reset, .in_valid(acc), .in_op(op),
      .in_a(req_word.left_lower), .in_b(req_word.right_lower), .out_value(c0));
   ia_corner u_c1 (.clock, .reset, .in_valid(acc), .in_op(op),
      .in_a(req_word.left_lower), .in_b(req_word.right_upper), .out_value(c1));
   ia_corner u_c2 (.clock, .reset, .in_valid(acc), .in_op(op),
      .in_a(req_word.left_upper), .in_b(req_word.right_lower), .out_value(c2));
   ia_corner u_c3 (.clock, .reset, .in_valid(acc), .in_op(op),
      .in_a(req_word.left_upper), .in_b(req_word.right_upper), .out_value(c3));

   ia_minmax u_mm (
      .clock, .reset,
      .in_ctl(ctl_ff[DivStages]),
      .in_c0(c0), .in_c1(c1), .in_c2(c2), .in_c3(c3),
      .in_dlo(dlo_ff[DivStages]), .in_dhi(dhi_ff[DivStages]),
      .out_strobe(rsp_strobe), .out_rsp(rsp_word)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##35 rsp_strobe)
      else $error("response missing after fixed latency");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(ctl_ff[DivStages].valid, 2))
      else $error("response without request");
   a_direct_err: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[0].valid && ctl_ff[0].direct |-> !ctl_ff[0].err)
      else $error("add/sub flagged error");

endmodule
